// ===== design/cau_pkg.sv =====
// shared types and constants for the complex arithmetic unit
`default_nettype none
package cau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  // width of an exact product, a sum of products, and a sum of two operands
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int ACC_W      = PROD_W + 1;
  localparam int SUM_W      = DATA_WIDTH + 1;
  // shift that lines the scaled numerator up with the quotient range
  localparam int ALIGN_SH   = DATA_WIDTH - FRAC_BITS;

  localparam logic [PROD_W-1:0] SAT_LIM = PROD_W'(1) << (DATA_WIDTH - 1);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // one item as it travels down the divider stages
  typedef struct packed {
    logic                  is_div;
    logic                  dz;
    logic                  re_neg;
    logic                  im_neg;
    logic                  re_big;
    logic                  im_big;
    logic [PROD_W-1:0]     re_mag;
    logic [PROD_W-1:0]     im_mag;
    logic [PROD_W-1:0]     den;
    logic [PROD_W-1:0]     re_rem;
    logic [PROD_W-1:0]     im_rem;
    logic [DATA_WIDTH-1:0] re_feed;
    logic [DATA_WIDTH-1:0] im_feed;
    logic [DATA_WIDTH-1:0] re_q;
    logic [DATA_WIDTH-1:0] im_q;
  } div_item_t;

endpackage
`default_nettype wire

// ===== design/cau_front.sv =====
// input, multiply, combine, magnitude and divider setup stages
`default_nettype none
module cau_front
  import cau_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         adv,
  input  wire logic                         in_valid,
  input  wire logic [1:0]                   op,
  input  wire logic signed [DATA_WIDTH-1:0] a_re,
  input  wire logic signed [DATA_WIDTH-1:0] a_im,
  input  wire logic signed [DATA_WIDTH-1:0] b_re,
  input  wire logic signed [DATA_WIDTH-1:0] b_im,
  output logic                              item_valid,
  output div_item_t                         item
);

  // stage a: operand registers
  logic                         v_a;
  op_t                          op_a;
  logic signed [DATA_WIDTH-1:0] ar, ai, br, bi;

  // stage b: products and sums
  logic                         v_b;
  op_t                          op_b;
  logic                         dz_b;
  logic signed [PROD_W-1:0]     p_rr, p_ii, p_ri, p_ir, sq_r, sq_i;
  logic signed [SUM_W-1:0]      sum_re, sum_im;

  // stage c: combined signed results and divisor
  logic                         v_c;
  op_t                          op_c;
  logic                         dz_c;
  logic signed [ACC_W-1:0]      re_c, im_c;
  logic [PROD_W-1:0]            den_c;

  // stage d: sign and magnitude
  logic                         v_d;
  op_t                          op_d;
  logic                         dz_d;
  logic                         re_neg_d, im_neg_d;
  logic [PROD_W-1:0]            re_mag_d, im_mag_d, den_d;

  logic [ACC_W-1:0]             re_abs, im_abs;
  logic [PROD_W-1:0]            re_top, im_top;
  div_item_t                    item_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      item_valid <= 1'b0;
    end else if (adv) begin
      v_a <= in_valid;
      v_b <= v_a;
      v_c <= v_b;
      v_d <= v_c;
      item_valid <= v_d;
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (adv) begin
      op_a <= op_t'(op);
      ar   <= a_re;
      ai   <= a_im;
      br   <= b_re;
      bi   <= b_im;
    end
  end

  // one multiply per product, exact
  always_ff @(posedge clk) begin
    if (adv) begin
      op_b <= op_a;
      dz_b <= (op_a == OP_DIV) && (br == '0) && (bi == '0);
      p_rr <= PROD_W'(ar) * PROD_W'(br);
      p_ii <= PROD_W'(ai) * PROD_W'(bi);
      p_ri <= PROD_W'(ar) * PROD_W'(bi);
      p_ir <= PROD_W'(ai) * PROD_W'(br);
      sq_r <= PROD_W'(br) * PROD_W'(br);
      sq_i <= PROD_W'(bi) * PROD_W'(bi);
      if (op_a == OP_SUB) begin
        sum_re <= SUM_W'(ar) - SUM_W'(br);
        sum_im <= SUM_W'(ai) - SUM_W'(bi);
      end else begin
        sum_re <= SUM_W'(ar) + SUM_W'(br);
        sum_im <= SUM_W'(ai) + SUM_W'(bi);
      end
    end
  end

  // combine products by operation
  always_ff @(posedge clk) begin
    if (adv) begin
      op_c  <= op_b;
      dz_c  <= dz_b;
      den_c <= $unsigned(sq_r) + $unsigned(sq_i);
      case (op_b)
        OP_MUL: begin
          re_c <= ACC_W'(p_rr) - ACC_W'(p_ii);
          im_c <= ACC_W'(p_ri) + ACC_W'(p_ir);
        end
        OP_DIV: begin
          re_c <= ACC_W'(p_rr) + ACC_W'(p_ii);
          im_c <= ACC_W'(p_ir) - ACC_W'(p_ri);
        end
        default: begin
          re_c <= ACC_W'(sum_re);
          im_c <= ACC_W'(sum_im);
        end
      endcase
    end
  end

  // sign and magnitude, multiply truncates toward zero
  assign re_abs = re_c[ACC_W-1] ? $unsigned(-re_c) : $unsigned(re_c);
  assign im_abs = im_c[ACC_W-1] ? $unsigned(-im_c) : $unsigned(im_c);

  always_ff @(posedge clk) begin
    if (adv) begin
      op_d  <= op_c;
      dz_d  <= dz_c;
      den_d <= den_c;
      if (dz_c) begin
        re_neg_d <= 1'b0;
        im_neg_d <= 1'b0;
        re_mag_d <= '0;
        im_mag_d <= '0;
      end else if (op_c == OP_MUL) begin
        re_neg_d <= re_c[ACC_W-1];
        im_neg_d <= im_c[ACC_W-1];
        re_mag_d <= re_abs[PROD_W-1:0] >> FRAC_BITS;
        im_mag_d <= im_abs[PROD_W-1:0] >> FRAC_BITS;
      end else begin
        re_neg_d <= re_c[ACC_W-1];
        im_neg_d <= im_c[ACC_W-1];
        re_mag_d <= re_abs[PROD_W-1:0];
        im_mag_d <= im_abs[PROD_W-1:0];
      end
    end
  end

  // divider setup: quotient range check and first partial remainder
  assign re_top = re_mag_d >> ALIGN_SH;
  assign im_top = im_mag_d >> ALIGN_SH;

  always_comb begin
    item_next         = '0;
    item_next.is_div  = (op_d == OP_DIV) && !dz_d;
    item_next.dz      = dz_d;
    item_next.re_neg  = re_neg_d;
    item_next.im_neg  = im_neg_d;
    item_next.re_mag  = re_mag_d;
    item_next.im_mag  = im_mag_d;
    item_next.den     = den_d;
    item_next.re_big  = item_next.is_div && (re_top >= den_d);
    item_next.im_big  = item_next.is_div && (im_top >= den_d);
    item_next.re_rem  = re_top;
    item_next.im_rem  = im_top;
    item_next.re_feed = re_mag_d[DATA_WIDTH-1:0] << FRAC_BITS;
    item_next.im_feed = im_mag_d[DATA_WIDTH-1:0] << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item <= item_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/cau_div_step.sv =====
// one restoring division step for both result parts
`default_nettype none
module cau_div_step
  import cau_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      adv,
  input  wire logic      step_in_valid,
  input  wire div_item_t step_in,
  output logic           step_out_valid,
  output div_item_t      step_out
);

  logic [ACC_W-1:0] re_try, im_try;
  logic             re_ge, im_ge;
  div_item_t        step_next;

  // shift in the next numerator bit and trial subtract
  assign re_try = {step_in.re_rem, step_in.re_feed[DATA_WIDTH-1]};
  assign im_try = {step_in.im_rem, step_in.im_feed[DATA_WIDTH-1]};
  assign re_ge  = re_try >= {1'b0, step_in.den};
  assign im_ge  = im_try >= {1'b0, step_in.den};

  always_comb begin
    step_next         = step_in;
    step_next.re_rem  = re_ge ? PROD_W'(re_try - {1'b0, step_in.den}) : PROD_W'(re_try);
    step_next.im_rem  = im_ge ? PROD_W'(im_try - {1'b0, step_in.den}) : PROD_W'(im_try);
    step_next.re_feed = step_in.re_feed << 1;
    step_next.im_feed = step_in.im_feed << 1;
    step_next.re_q    = {step_in.re_q[DATA_WIDTH-2:0], re_ge};
    step_next.im_q    = {step_in.im_q[DATA_WIDTH-2:0], im_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_out_valid <= 1'b0;
    end else if (adv) begin
      step_out_valid <= step_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      step_out <= step_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/cau_back.sv =====
// saturation and output register
`default_nettype none
module cau_back
  import cau_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    adv,
  input  wire logic                    item_valid,
  input  wire div_item_t               item,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] res_re,
  output logic signed [DATA_WIDTH-1:0] res_im,
  output logic                         div_zero,
  output logic                         overflow
);

  // returns {saturated flag, two's complement result}
  function automatic logic [DATA_WIDTH:0] sat_part(
    input logic              neg,
    input logic              big,
    input logic [PROD_W-1:0] mag
  );
    logic [PROD_W-1:0] neg_mag;
    logic              ovf;
    logic [DATA_WIDTH-1:0] val;
    neg_mag = -mag;
    if (neg) begin
      ovf = big || (mag > SAT_LIM);
      val = ovf ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : neg_mag[DATA_WIDTH-1:0];
    end else begin
      ovf = big || (mag > (SAT_LIM - PROD_W'(1)));
      val = ovf ? {1'b0, {(DATA_WIDTH-1){1'b1}}} : mag[DATA_WIDTH-1:0];
    end
    return {ovf, val};
  endfunction

  logic [PROD_W-1:0]   re_mag, im_mag;
  logic [DATA_WIDTH:0] re_sat, im_sat;

  // quotient replaces the magnitude for divide items
  assign re_mag = item.is_div ? PROD_W'(item.re_q) : item.re_mag;
  assign im_mag = item.is_div ? PROD_W'(item.im_q) : item.im_mag;
  assign re_sat = sat_part(item.re_neg, item.is_div && item.re_big, re_mag);
  assign im_sat = sat_part(item.im_neg, item.is_div && item.im_big, im_mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_re   <= re_sat[DATA_WIDTH-1:0];
      res_im   <= im_sat[DATA_WIDTH-1:0];
      div_zero <= item.dz;
      overflow <= re_sat[DATA_WIDTH] | im_sat[DATA_WIDTH];
    end
  end

endmodule
`default_nettype wire

// ===== design/complex_arith_unit_core.sv =====
// top level of the complex arithmetic unit
// Complex ALU on signed Q16.16 operands: add, subtract, multiply and divide,
// one beat accepted per cycle while the pipe is not stalled, and one result beat per input beat, in order.
// Every item takes the same path of 5 front stages (operand register, multiply,
// combine, magnitude, divider setup), 32 restoring divider steps (one quotient
// bit per stage) and the output register. All stages move together: a stall at the
// output holds the whole pipe and pushes back on the input in the same cycle.
// A divide by zero gives zero with div_zero set; saturated results set overflow.
`default_nettype none
module complex_arith_unit_core
  import cau_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   op,
  input  wire logic signed [DATA_WIDTH-1:0] a_re,
  input  wire logic signed [DATA_WIDTH-1:0] a_im,
  input  wire logic signed [DATA_WIDTH-1:0] b_re,
  input  wire logic signed [DATA_WIDTH-1:0] b_im,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0]      res_re,
  output logic signed [DATA_WIDTH-1:0]      res_im,
  output logic                              div_zero,
  output logic                              overflow
);

  logic      adv;
  logic      chain_v [DATA_WIDTH+1];
  div_item_t chain   [DATA_WIDTH+1];

  // pipe advances unless a finished beat is held at the output
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  cau_front u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (in_valid),
    .op         (op),
    .a_re       (a_re),
    .a_im       (a_im),
    .b_re       (b_re),
    .b_im       (b_im),
    .item_valid (chain_v[0]),
    .item       (chain[0])
  );

  // divider steps, most significant quotient bit first
  for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_div
    cau_div_step u_step (
      .clk            (clk),
      .rst            (rst),
      .adv            (adv),
      .step_in_valid  (chain_v[g]),
      .step_in        (chain[g]),
      .step_out_valid (chain_v[g+1]),
      .step_out       (chain[g+1])
    );
  end

  cau_back u_back (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .item_valid (chain_v[DATA_WIDTH]),
    .item       (chain[DATA_WIDTH]),
    .out_valid  (out_valid),
    .res_re     (res_re),
    .res_im     (res_im),
    .div_zero   (div_zero),
    .overflow   (overflow)
  );

  // zero divisor never runs the divider and carries a zero result
  a_dz_setup: assert property (@(posedge clk) disable iff (rst)
    chain_v[0] && chain[0].dz |-> !chain[0].is_div && chain[0].re_mag == '0
      && chain[0].im_mag == '0)
    else $error("zero divisor item not cleared at divider entry");

  // a zero divisor beat is zero and never saturated
  a_dz_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero |-> !overflow && res_re == '0 && res_im == '0)
    else $error("zero divisor result not zero");

  // saturation lands on a bound
  a_ovf_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |->
      res_re == {1'b1, {(DATA_WIDTH-1){1'b0}}} || res_re == {1'b0, {(DATA_WIDTH-1){1'b1}}} ||
      res_im == {1'b1, {(DATA_WIDTH-1){1'b0}}} || res_im == {1'b0, {(DATA_WIDTH-1){1'b1}}})
    else $error("overflow without a saturated part");

  // a held output beat freezes the divider chain as well
  a_hold_chain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(chain_v[DATA_WIDTH]) && $stable(chain[DATA_WIDTH]))
    else $error("divider chain moved during output stall");

endmodule
`default_nettype wire
